### hw/rtl/assert_macros.svh
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_DEF(lbl, prop, msg) `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

### hw/rtl/wca_pkg.sv
`default_nettype none

package wca_pkg;

  localparam int unsigned MAX_LENGTH_DEF = 4096;
  localparam int unsigned COS_DEPTH_DEF  = 1024;

  localparam int unsigned LenW    = 13;
  localparam int unsigned PosW    = 12;
  localparam int unsigned SmpW    = 16;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned TypeW   = 3;
  localparam int unsigned RecW    = 33;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_TYPE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LENGTH = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CENTER = 2'd2;

  typedef enum logic [TypeW-1:0] {
    WIN_BOXCAR   = 3'd0,
    WIN_TRIANGLE = 3'd1,
    WIN_ASYM     = 3'd2,
    WIN_HANN     = 3'd3,
    WIN_HAMMING  = 3'd4,
    WIN_BLACKMAN = 3'd5
  } win_e;

  localparam logic [LenW-1:0] LENGTH_RST = 13'd1024;
  localparam logic [PosW-1:0] CENTER_RST = 12'd512;

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  localparam logic [CoefW-1:0] COEF_ONE = 16'd32768;

  typedef struct packed {
    logic [RecW-1:0] len1;
    logic [RecW-1:0] center;
    logic [RecW-1:0] tail;
  } recip_t;

endpackage

`default_nettype wire

### hw/rtl/window_coefficient_apply_top.sv
// Stages A to G are registered in turn between an input transfer and its result.
// Throughput: one item per cycle; stalls propagate stage by stage with no loss.
// Reset: config returns to Hann, length 1024, center 512; pipeline empties.
// After reset and after each length or center write the reciprocal unit runs
// its three divisions in turn, with in_ready_o held low.
`default_nettype none
`include "assert_macros.svh"

module window_coefficient_apply_top #(
  parameter int unsigned MaxLength = wca_pkg::MAX_LENGTH_DEF,
  parameter int unsigned CosDepth  = wca_pkg::COS_DEPTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [wca_pkg::SmpW-1:0]     sample_i,
  input  wire logic        [wca_pkg::PosW-1:0]     position_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed      [wca_pkg::SmpW-1:0]     windowed_o,
  output logic             [wca_pkg::CoefW-1:0]    coefficient_o,
  input  wire logic                                cfg_we_i,
  input  wire logic        [wca_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic        [wca_pkg::LenW-1:0]     cfg_wdata_i
);

  localparam int unsigned LenW  = wca_pkg::LenW;
  localparam int unsigned PosW  = wca_pkg::PosW;
  localparam int unsigned SmpW  = wca_pkg::SmpW;
  localparam int unsigned CoefW = wca_pkg::CoefW;
  localparam int unsigned RecW  = wca_pkg::RecW;
  localparam int unsigned SW    = $clog2(4 * CosDepth);
  localparam int unsigned AW    = $clog2(CosDepth + 1);
  localparam int unsigned PhW   = 33 + SW;
  localparam int unsigned ProdW = PosW + RecW;
  localparam int unsigned NSt   = 7;

  localparam logic [SW:0] D1 = (SW+1)'(CosDepth);
  localparam logic [SW:0] D2 = (SW+1)'(2 * CosDepth);
  localparam logic [SW:0] D3 = (SW+1)'(3 * CosDepth);
  localparam logic [SW:0] D4 = (SW+1)'(4 * CosDepth);

  typedef struct packed {
    logic signed [SmpW-1:0] sample;
    logic                   in_frame;
    logic                   low_half;
    logic                   before_c;
    logic [PosW-1:0]        mul_a;
    logic [RecW-1:0]        mul_b;
  } sa_t;

  typedef struct packed {
    logic signed [SmpW-1:0] sample;
    logic                   in_frame;
    logic                   low_half;
    logic                   before_c;
    logic [ProdW-1:0]       prod;
  } sb_t;

  typedef struct packed {
    logic signed [SmpW-1:0] sample;
    logic                   in_frame;
    logic [CoefW-1:0]       lin;
    logic [SW-1:0]          step;
  } sc_t;

  typedef struct packed {
    logic signed [SmpW-1:0] sample;
    logic                   in_frame;
    logic [CoefW-1:0]       lin;
    logic                   neg1;
    logic                   neg2;
  } sd_t;

  typedef struct packed {
    logic signed [SmpW-1:0] sample;
    logic [CoefW-1:0]       coef;
  } se_t;

  typedef struct packed {
    logic signed [32:0] wprod;
    logic [CoefW-1:0]   coef;
  } sf_t;

  typedef struct packed {
    logic           neg;
    logic [AW-1:0]  addr;
  } cos_ref_t;

  function automatic cos_ref_t cos_ref(logic [SW-1:0] s);
    logic [SW:0] sx;
    logic [SW:0] r;
    cos_ref_t    res;
    sx = {1'b0, s};
    if (sx < D1) begin
      r = sx;
      res.neg = 1'b0;
      res.addr = AW'(r);
    end else if (sx < D2) begin
      r = sx - D1;
      res.neg = 1'b1;
      res.addr = AW'(D1 - r);
    end else if (sx < D3) begin
      r = sx - D2;
      res.neg = 1'b1;
      res.addr = AW'(r);
    end else begin
      r = sx - D3;
      res.neg = 1'b0;
      res.addr = AW'(D1 - r);
    end
    return res;
  endfunction

  function automatic logic [CoefW-1:0] round_clamp(logic signed [33:0] v);
    logic signed [33:0] t;
    t = v >>> 15;
    if (v < 0) return '0;
    if (t > 34'sd32768) return wca_pkg::COEF_ONE;
    return CoefW'(t);
  endfunction

  // configuration
  logic [2:0]      type_q;
  logic [LenW-1:0] len_q;
  logic [PosW-1:0] center_q;
  logic [LenW-1:0] eff_len;
  logic            recip_start;
  logic            recip_busy;
  wca_pkg::recip_t recip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q   <= wca_pkg::WIN_HANN;
      len_q    <= wca_pkg::LENGTH_RST;
      center_q <= wca_pkg::CENTER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wca_pkg::CFG_TYPE:   type_q   <= cfg_wdata_i[2:0];
        wca_pkg::CFG_LENGTH: len_q    <= cfg_wdata_i;
        wca_pkg::CFG_CENTER: center_q <= cfg_wdata_i[PosW-1:0];
        default: ;
      endcase
    end
  end

  assign eff_len     = (32'(len_q) > 32'(MaxLength)) ? LenW'(MaxLength) : len_q;
  assign recip_start = cfg_we_i && (cfg_idx_i inside {wca_pkg::CFG_LENGTH, wca_pkg::CFG_CENTER});

  wca_recip u_recip (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (recip_start),
    .eff_len_i (eff_len),
    .center_i  (center_q),
    .recip_o   (recip),
    .busy_o    (recip_busy)
  );

  // pipeline control
  logic [NSt-1:0] vld_q;
  logic [NSt-1:0] adv;
  logic           in_fire;

  always_comb begin
    adv[NSt-1] = !vld_q[NSt-1] || out_ready_i;
    for (int k = NSt - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_ready_o = adv[0] && !recip_busy;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_fire;
      for (int k = 1; k < NSt; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // stage A: frame checks, multiplier operand select
  sa_t a_d, a_q;
  logic before_c;

  assign before_c = position_i < center_q;

  always_comb begin
    a_d.sample   = sample_i;
    a_d.in_frame = {1'b0, position_i} < eff_len;
    a_d.low_half = {1'b0, position_i} < (eff_len >> 1);
    a_d.before_c = before_c;
    if (type_q == wca_pkg::WIN_ASYM) begin
      a_d.mul_a = before_c ? position_i : position_i - center_q;
      a_d.mul_b = before_c ? recip.center : recip.tail;
    end else begin
      a_d.mul_a = position_i;
      a_d.mul_b = recip.len1;
    end
  end

  // stage B: phase or ramp product
  sb_t b_d, b_q;

  always_comb begin
    b_d.sample   = a_q.sample;
    b_d.in_frame = a_q.in_frame;
    b_d.low_half = a_q.low_half;
    b_d.before_c = a_q.before_c;
    b_d.prod     = ProdW'(a_q.mul_a) * ProdW'(a_q.mul_b);
  end

  // stage C: table step, linear windows
  sc_t c_d, c_q;
  logic [PhW-1:0]   ph;
  logic [SW:0]      sraw;
  logic [ProdW-1:0] tri_sum;
  logic [ProdW-1:0] as_sum;
  logic [28:0]      tri_t;
  logic [27:0]      as_t;

  assign ph      = PhW'(b_q.prod[31:0]) * PhW'(D4) + PhW'(64'h8000_0000);
  assign sraw    = ph[PhW-1:32];
  assign tri_sum = b_q.prod + ProdW'(32768);
  assign as_sum  = b_q.prod + ProdW'(65536);
  assign tri_t   = tri_sum[ProdW-1:16];
  assign as_t    = as_sum[ProdW-1:17];

  always_comb begin
    c_d.sample   = b_q.sample;
    c_d.in_frame = b_q.in_frame;
    c_d.step     = (sraw >= D4) ? SW'(sraw - D4) : SW'(sraw);
    case (type_q)
      wca_pkg::WIN_TRIANGLE: begin
        if (b_q.low_half) begin
          c_d.lin = (tri_t > 29'd32768) ? wca_pkg::COEF_ONE : tri_t[CoefW-1:0];
        end else if (tri_t >= 29'd65536) begin
          c_d.lin = '0;
        end else if (tri_t <= 29'd32768) begin
          c_d.lin = wca_pkg::COEF_ONE;
        end else begin
          c_d.lin = CoefW'(17'd65536 - tri_t[16:0]);
        end
      end
      wca_pkg::WIN_ASYM: begin
        if (b_q.before_c) begin
          c_d.lin = (as_t > 28'd32768) ? wca_pkg::COEF_ONE : as_t[CoefW-1:0];
        end else if (as_t >= 28'd32768) begin
          c_d.lin = '0;
        end else begin
          c_d.lin = CoefW'(17'd32768 - as_t[16:0]);
        end
      end
      default: c_d.lin = wca_pkg::COEF_ONE;
    endcase
  end

  // stage D: quarter-wave lookup
  sd_t         d_q;
  cos_ref_t    ref1;
  cos_ref_t    ref2;
  logic [SW:0] dbl;
  logic [SW:0] dbl_m;
  logic [15:0] rom1;
  logic [15:0] rom2;

  assign dbl   = {c_q.step, 1'b0};
  assign dbl_m = (dbl >= D4) ? dbl - D4 : dbl;
  assign ref1  = cos_ref(c_q.step);
  assign ref2  = cos_ref(dbl_m[SW-1:0]);

  wca_cos_rom #(
    .CosDepth (CosDepth),
    .AddrW    (AW)
  ) u_cos_rom (
    .clk_i    (clk_i),
    .en_i     (adv[3]),
    .addr_a_i (ref1.addr),
    .addr_b_i (ref2.addr),
    .data_a_o (rom1),
    .data_b_o (rom2)
  );

  // stage E: cosine windows, coefficient select, out-of-frame zeroing
  se_t e_d, e_q;
  logic signed [16:0] c1;
  logic signed [16:0] c2;
  logic signed [17:0] hs;
  logic signed [33:0] ham;
  logic signed [33:0] blk;

  always_comb begin
    c1  = d_q.neg1 ? -$signed({1'b0, rom1}) : $signed({1'b0, rom1});
    c2  = d_q.neg2 ? -$signed({1'b0, rom2}) : $signed({1'b0, rom2});
    hs  = 18'sd32769 - 18'(c1);
    ham = 34'sd579829760 - 34'sd15073 * 34'(c1) + 34'sd16384;
    blk = 34'sd450985984 - 34'sd16384 * 34'(c1) + 34'sd2621 * 34'(c2) + 34'sd16384;
    e_d.sample = d_q.sample;
    case (type_q)
      wca_pkg::WIN_HANN:     e_d.coef = CoefW'(hs >>> 1);
      wca_pkg::WIN_HAMMING:  e_d.coef = round_clamp(ham);
      wca_pkg::WIN_BLACKMAN: e_d.coef = round_clamp(blk);
      default:               e_d.coef = d_q.lin;
    endcase
    if (!d_q.in_frame) e_d.coef = '0;
  end

  // stage F: weighting product
  sf_t f_d, f_q;

  assign f_d.wprod = 33'(e_q.sample) * 33'($signed({1'b0, e_q.coef}));
  assign f_d.coef  = e_q.coef;

  // stage G: round and saturate
  logic signed [32:0]     wsum;
  logic signed [32:0]     wsh;
  logic signed [SmpW-1:0] w_d;
  logic signed [SmpW-1:0] w_q;
  logic [CoefW-1:0]       coef_q;

  assign wsum = f_q.wprod + 33'sd16384;
  assign wsh  = wsum >>> 15;

  always_comb begin
    if (wsh > 33'sd32767)       w_d = 16'sh7fff;
    else if (wsh < -33'sd32768) w_d = 16'sh8000;
    else                        w_d = SmpW'(wsh);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) a_q <= a_d;
    if (adv[1]) b_q <= b_d;
    if (adv[2]) c_q <= c_d;
    if (adv[3]) begin
      d_q.sample   <= c_q.sample;
      d_q.in_frame <= c_q.in_frame;
      d_q.lin      <= c_q.lin;
      d_q.neg1     <= ref1.neg;
      d_q.neg2     <= ref2.neg;
    end
    if (adv[4]) e_q <= e_d;
    if (adv[5]) f_q <= f_d;
    if (adv[6]) begin
      w_q    <= w_d;
      coef_q <= f_q.coef;
    end
  end

  assign out_valid_o   = vld_q[NSt-1];
  assign windowed_o    = w_q;
  assign coefficient_o = coef_q;

  `ASSERT_DEF(a_coef_range, out_valid_o |-> (coefficient_o <= wca_pkg::COEF_ONE), "coefficient above one")
  `ASSERT_DEF(a_out_of_frame_zero, (vld_q[3] && adv[4] && !d_q.in_frame) |=> (e_q.coef == '0), "nonzero coefficient past frame")
  `ASSERT_DEF(a_zero_coef_zero_out, (vld_q[5] && adv[6] && f_q.coef == '0) |=> (windowed_o == '0), "nonzero output for zero coefficient")

endmodule

`default_nettype wire

### hw/rtl/wca_recip.sv
`default_nettype none
`include "assert_macros.svh"

module wca_recip (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [wca_pkg::LenW-1:0]       eff_len_i,
  input  wire logic [wca_pkg::PosW-1:0]       center_i,
  output wca_pkg::recip_t                     recip_o,
  output logic                                busy_o
);

  localparam int unsigned LenW = wca_pkg::LenW;
  localparam int unsigned RecW = wca_pkg::RecW;

  typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_STEP} state_e;

  state_e          state_q;
  logic [1:0]      job_q;
  logic [5:0]      cnt_q;
  logic [LenW-1:0] div_q;
  logic [RecW-1:0] num_q;
  logic [LenW-1:0] rem_q;
  logic [RecW-1:0] quo_q;
  wca_pkg::recip_t recip_q;

  logic [LenW-1:0] divisor;
  logic [LenW:0]   rem2;
  logic            ge;
  logic [LenW-1:0] rem_d;
  logic [RecW-1:0] quo_d;
  logic [RecW-1:0] res;

  always_comb begin
    case (job_q)
      2'd0:    divisor = (eff_len_i == '0) ? '0 : eff_len_i - 1'b1;
      2'd1:    divisor = {1'b0, center_i};
      default: divisor = (eff_len_i > {1'b0, center_i}) ? eff_len_i - {1'b0, center_i} : '0;
    endcase
  end

  assign rem2  = {rem_q, num_q[RecW-1]};
  assign ge    = rem2 >= {1'b0, div_q};
  assign rem_d = ge ? LenW'(rem2 - {1'b0, div_q}) : rem2[LenW-1:0];
  assign quo_d = {quo_q[RecW-2:0], ge};
  assign res   = (div_q == '0) ? '0 : quo_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      job_q   <= '0;
      cnt_q   <= '0;
      div_q   <= '0;
      num_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      recip_q <= '0;
    end else if (start_i) begin
      state_q <= ST_LOAD;
      job_q   <= '0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          div_q   <= divisor;
          num_q   <= {1'b1, 32'd0} + RecW'(divisor >> 1);
          rem_q   <= '0;
          quo_q   <= '0;
          cnt_q   <= '0;
          state_q <= ST_STEP;
        end
        ST_STEP: begin
          rem_q <= rem_d;
          quo_q <= quo_d;
          num_q <= {num_q[RecW-2:0], 1'b0};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'(RecW - 1)) begin
            case (job_q)
              2'd0:    recip_q.len1   <= res;
              2'd1:    recip_q.center <= res;
              default: recip_q.tail   <= res;
            endcase
            if (job_q == 2'd2) begin
              state_q <= ST_IDLE;
            end else begin
              job_q   <= job_q + 1'b1;
              state_q <= ST_LOAD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign recip_o = recip_q;
  assign busy_o  = (state_q != ST_IDLE) || start_i;

  `ASSERT_DEF(a_rem_below_div, (state_q == ST_STEP) |-> (rem_q < div_q || div_q == '0), "remainder not below divisor")
  `ASSERT_DEF(a_job_bound, (state_q != ST_IDLE) |-> (job_q != 2'd3), "reciprocal job out of range")

endmodule

`default_nettype wire

### hw/rtl/wca_cos_rom.sv
`default_nettype none

module wca_cos_rom #(
  parameter int unsigned CosDepth = wca_pkg::COS_DEPTH_DEF,
  parameter int unsigned AddrW    = $clog2(CosDepth + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [AddrW-1:0] addr_a_i,
  input  wire logic [AddrW-1:0] addr_b_i,
  output logic      [15:0]      data_a_o,
  output logic      [15:0]      data_b_o
);

  typedef logic [15:0] rom_t [CosDepth+1];

  localparam longint CosDepthL = longint'(CosDepth);
  localparam longint Div240    = 64'sd240 * wca_pkg::Q30_ONE;
  localparam longint Div182    = 64'sd182 * wca_pkg::Q30_ONE;
  localparam longint Div132    = 64'sd132 * wca_pkg::Q30_ONE;
  localparam longint Div90     = 64'sd90 * wca_pkg::Q30_ONE;
  localparam longint Div56     = 64'sd56 * wca_pkg::Q30_ONE;
  localparam longint Div30     = 64'sd30 * wca_pkg::Q30_ONE;
  localparam longint Div12     = 64'sd12 * wca_pkg::Q30_ONE;
  localparam longint Div2      = 64'sd2 * wca_pkg::Q30_ONE;

  // quarter-wave cosine, Q30 angle, Horner Taylor series, rounded to Q15
  function automatic logic [15:0] quarter_cos(int unsigned k);
    longint x;
    longint x2;
    longint r;
    x  = longint'(k) * wca_pkg::HALF_PI_Q30 / CosDepthL;
    x2 = (x * x) >>> 30;
    r  = wca_pkg::Q30_ONE;
    r  = wca_pkg::Q30_ONE - (x2 * r) / Div240;
    r  = wca_pkg::Q30_ONE - (x2 * r) / Div182;
    r  = wca_pkg::Q30_ONE - (x2 * r) / Div132;
    r  = wca_pkg::Q30_ONE - (x2 * r) / Div90;
    r  = wca_pkg::Q30_ONE - (x2 * r) / Div56;
    r  = wca_pkg::Q30_ONE - (x2 * r) / Div30;
    r  = wca_pkg::Q30_ONE - (x2 * r) / Div12;
    r  = wca_pkg::Q30_ONE - (x2 * r) / Div2;
    if (r < 0) r = 0;
    r = (r + 64'sd16384) >>> 15;
    if (r > 64'sd32768) r = 64'sd32768;
    return 16'(r);
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int unsigned k = 0; k <= CosDepth; k++) begin
      t[k] = quarter_cos(k);
    end
    return t;
  endfunction

  localparam rom_t CosRom = build_rom();

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_o <= CosRom[addr_a_i];
      data_b_o <= CosRom[addr_b_i];
    end
  end

endmodule

`default_nettype wire
